// ----- src/tfm_pkg.sv -----
// Package for the typed FIFO mailbox: sizes, command and status codes,
// item structs and the control structs passed between the submodules.
// No dependencies.
`default_nettype none

package tfm_pkg;

   localparam int DEPTH         = 16;
   localparam int PAYLOAD_WIDTH = 32;
   localparam int IDX_W         = $clog2(DEPTH);
   localparam int CNT_W         = IDX_W;   // count never exceeds DEPTH-1
   localparam int AGE_W         = IDX_W;   // ages stay 1..count
   localparam int TYPE_W        = 16;
   localparam int PAY_IN_W      = 32;
   localparam int PAY_OUT_W     = 32;
   localparam int FILL_W        = 4;
   localparam int STATUS_W      = 2;

   localparam logic CMD_SEND = 1'b0;
   localparam logic CMD_RECV = 1'b1;

   localparam logic [STATUS_W-1:0] ST_STORED   = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RECEIVED = 2'd2;
   localparam logic [STATUS_W-1:0] ST_NOMATCH  = 2'd3;

   typedef struct packed {
      logic                cmd;
      logic [TYPE_W-1:0]   msg_type;
      logic [PAY_IN_W-1:0] payload_in;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0]  status;
      logic [PAY_OUT_W-1:0] payload_out;
      logic [FILL_W-1:0]    fill_count;
   } rsp_type;

   // sequencer -> store
   typedef struct packed {
      logic                     wr_en;
      logic [IDX_W-1:0]         wr_idx;
      logic [TYPE_W-1:0]        wr_type;
      logic [PAYLOAD_WIDTH-1:0] wr_payload;
      logic [AGE_W-1:0]         wr_age;
      logic                     age_adj;
      logic [AGE_W-1:0]         gone_age;
      logic                     rd_en;
      logic [IDX_W-1:0]         rd_idx;
   } store_cmd_type;

   // store -> match unit, registered read data
   typedef struct packed {
      logic [TYPE_W-1:0]        rd_type;
      logic [PAYLOAD_WIDTH-1:0] rd_payload;
      logic [AGE_W-1:0]         rd_age;
   } store_rd_type;

   // sequencer -> match unit
   typedef struct packed {
      logic              clear;
      logic              rd_valid;
      logic [IDX_W-1:0]  rd_idx;
      logic [IDX_W-1:0]  last_idx;
      logic [TYPE_W-1:0] want_type;
   } match_cmd_type;

   // match unit -> sequencer
   typedef struct packed {
      logic                     found;
      logic [IDX_W-1:0]         best_idx;
      logic [AGE_W-1:0]         best_age;
      logic [PAYLOAD_WIDTH-1:0] best_payload;
      logic [TYPE_W-1:0]        last_type;
      logic [PAYLOAD_WIDTH-1:0] last_payload;
      logic [AGE_W-1:0]         last_age;
   } match_type;

endpackage

`default_nettype wire

// ----- src/typed_fifo_mailbox.sv -----
// Typed FIFO mailbox: sends append, receives take the oldest entry of a type.
// A send, a refused send or a receive on an empty mailbox answers on rsp_strobe in the
// cycle after the accept, and busy stays low, so a new item can follow the next cycle.
// A receive with entries stored raises busy while it reads one slot per cycle (scan), then
// finishes the compare (drain) and compacts (done); its answer is registered after that.
// Results cannot be stalled. Reset clears the fill count and control, not the entries.
`default_nettype none

module typed_fifo_mailbox (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire tfm_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output tfm_pkg::rsp_type      rsp_data
);
   import tfm_pkg::*;

   store_cmd_type scmd;
   store_rd_type  srd;
   match_cmd_type mcmd;
   match_type     best;
   logic          rsp_load;
   rsp_type       rsp_next;
   logic          rsp_strobe_ff;
   rsp_type       rsp_data_ff;

   tfm_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req      (req_data),
      .busy     (busy),
      .scmd     (scmd),
      .mcmd     (mcmd),
      .best     (best),
      .rsp_load (rsp_load),
      .rsp_next (rsp_next)
   );

   tfm_store u_store (
      .clock (clock),
      .cmd   (scmd),
      .rd    (srd)
   );

   tfm_match u_match (
      .clock (clock),
      .reset (reset),
      .mcmd  (mcmd),
      .rd    (srd),
      .best  (best)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff <= rsp_next;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

`default_nettype wire

// ----- src/tfm_store.sv -----
// Message store: type and payload memories with one write and one registered
// read port, plus the per-slot age registers with their decrement cells.
// Depends on tfm_pkg.
`default_nettype none

module tfm_store (
   input  wire logic                   clock,
   input  wire tfm_pkg::store_cmd_type cmd,
   output tfm_pkg::store_rd_type       rd
);
   import tfm_pkg::*;

   logic [TYPE_W-1:0]        type_mem [DEPTH];
   logic [PAYLOAD_WIDTH-1:0] pay_mem  [DEPTH];
   logic [AGE_W-1:0]         age_ff   [DEPTH];
   logic [AGE_W-1:0]         age_in   [DEPTH];
   store_rd_type             rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         type_mem[cmd.wr_idx] <= cmd.wr_type;
         pay_mem[cmd.wr_idx]  <= cmd.wr_payload;
      end
      if (cmd.rd_en) begin
         rd_ff.rd_type    <= type_mem[cmd.rd_idx];
         rd_ff.rd_payload <= pay_mem[cmd.rd_idx];
         rd_ff.rd_age     <= age_ff[cmd.rd_idx];
      end
   end

   // each slot: take the moved-in age, then close the gap left by the removed age
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         age_in[i] = age_ff[i];
         if (cmd.wr_en && (cmd.wr_idx == IDX_W'(i))) begin
            age_in[i] = cmd.wr_age;
         end
         if (cmd.age_adj && (age_in[i] > cmd.gone_age)) begin
            age_in[i] = age_in[i] - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         age_ff[i] <= age_in[i];
      end
   end

   assign rd = rd_ff;

endmodule

`default_nettype wire

// ----- src/tfm_match.sv -----
// Shared compare unit: looks at one read-back entry per cycle and keeps the
// oldest entry of the wanted type, plus a copy of the last stored entry.
// Depends on tfm_pkg.
`default_nettype none

module tfm_match (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire tfm_pkg::match_cmd_type mcmd,
   input  wire tfm_pkg::store_rd_type  rd,
   output tfm_pkg::match_type          best
);
   import tfm_pkg::*;

   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [AGE_W-1:0]         best_age_ff;
   logic [PAYLOAD_WIDTH-1:0] best_pay_ff;
   logic [TYPE_W-1:0]        last_type_ff;
   logic [PAYLOAD_WIDTH-1:0] last_pay_ff;
   logic [AGE_W-1:0]         last_age_ff;
   logic                     take;

   // strict compare keeps the lowest slot on equal ages
   assign take = mcmd.rd_valid && (rd.rd_type == mcmd.want_type) &&
                 (!found_ff || (rd.rd_age < best_age_ff));

   always_comb begin
      found_in = found_ff;
      if (mcmd.clear) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         best_idx_ff <= mcmd.rd_idx;
         best_age_ff <= rd.rd_age;
         best_pay_ff <= rd.rd_payload;
      end
      if (mcmd.rd_valid && (mcmd.rd_idx == mcmd.last_idx)) begin
         last_type_ff <= rd.rd_type;
         last_pay_ff  <= rd.rd_payload;
         last_age_ff  <= rd.rd_age;
      end
   end

   assign best.found        = found_ff;
   assign best.best_idx     = best_idx_ff;
   assign best.best_age     = best_age_ff;
   assign best.best_payload = best_pay_ff;
   assign best.last_type    = last_type_ff;
   assign best.last_payload = last_pay_ff;
   assign best.last_age     = last_age_ff;

endmodule

`default_nettype wire

// ----- src/tfm_seq.sv -----
// Sequencer: takes commands, handles sends in one step, walks the store one
// slot per cycle for a receive, then compacts and answers.
// Depends on tfm_pkg.
`default_nettype none

module tfm_seq (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire tfm_pkg::req_type       req,
   output logic                        busy,
   output tfm_pkg::store_cmd_type      scmd,
   output tfm_pkg::match_cmd_type      mcmd,
   input  wire tfm_pkg::match_type     best,
   output logic                        rsp_load,
   output tfm_pkg::rsp_type            rsp_next
);
   import tfm_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [TYPE_W-1:0] want_ff, want_in;
   logic              rdv_ff, rdv_in;
   logic [IDX_W-1:0]  rdidx_ff, rdidx_in;
   logic [IDX_W-1:0]  last_idx;

   assign last_idx = IDX_W'(count_ff - 1'b1);
   assign busy     = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      idx_in   = idx_ff;
      want_in  = want_ff;
      rdv_in   = 1'b0;
      rdidx_in = rdidx_ff;

      scmd            = '0;
      scmd.wr_payload = PAYLOAD_WIDTH'(req.payload_in);
      scmd.wr_type    = req.msg_type;
      scmd.wr_idx     = IDX_W'(count_ff);
      scmd.wr_age     = AGE_W'(count_ff) + 1'b1;
      scmd.rd_idx     = idx_ff;

      mcmd.clear     = 1'b0;
      mcmd.rd_valid  = rdv_ff;
      mcmd.rd_idx    = rdidx_ff;
      mcmd.last_idx  = last_idx;
      mcmd.want_type = want_ff;

      rsp_load             = 1'b0;
      rsp_next.status      = ST_NOMATCH;
      rsp_next.payload_out = '0;
      rsp_next.fill_count  = FILL_W'(count_ff);

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req.cmd == CMD_SEND) begin
                  rsp_load = 1'b1;
                  if (count_ff >= CNT_W'(DEPTH - 1)) begin
                     rsp_next.status = ST_FULL;
                  end else begin
                     scmd.wr_en          = 1'b1;
                     count_in            = count_ff + 1'b1;
                     rsp_next.status     = ST_STORED;
                     rsp_next.fill_count = FILL_W'(count_in);
                  end
               end else if (count_ff == '0) begin
                  rsp_load = 1'b1;
               end else begin
                  want_in    = req.msg_type;
                  idx_in     = '0;
                  mcmd.clear = 1'b1;
                  state_in   = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            scmd.rd_en = 1'b1;
            rdv_in     = 1'b1;
            rdidx_in   = idx_ff;
            if (idx_ff == last_idx) begin
               state_in = S_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_DRAIN: begin
            // last read-back entry is compared this cycle
            state_in = S_DONE;
         end
         S_DONE: begin
            rsp_load = 1'b1;
            state_in = S_IDLE;
            if (best.found) begin
               // last entry fills the hole; a self-move when it was picked
               scmd.wr_en           = 1'b1;
               scmd.wr_idx          = best.best_idx;
               scmd.wr_type         = best.last_type;
               scmd.wr_payload      = best.last_payload;
               scmd.wr_age          = best.last_age;
               scmd.age_adj         = 1'b1;
               scmd.gone_age        = best.best_age;
               count_in             = count_ff - 1'b1;
               rsp_next.status      = ST_RECEIVED;
               rsp_next.payload_out = PAY_OUT_W'(best.best_payload);
               rsp_next.fill_count  = FILL_W'(count_in);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         rdv_ff   <= rdv_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      want_ff  <= want_in;
      rdidx_ff <= rdidx_in;
   end

endmodule

`default_nettype wire

// ----- src/tfm_checker.sv -----
// Port-level checker for the typed FIFO mailbox and its bind to the top level.
// Depends on tfm_pkg and typed_fifo_mailbox.
`default_nettype none

module tfm_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire logic             busy,
   input wire tfm_pkg::req_type req_data,
   input wire logic             rsp_strobe,
   input wire tfm_pkg::rsp_type rsp_data
);
   import tfm_pkg::*;

   a_send_answers_next: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.cmd == CMD_SEND)) |=> rsp_strobe)
      else $error("send item not answered in the next cycle");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == ST_FULL)) |->
         (rsp_data.fill_count == FILL_W'(DEPTH - 1)))
      else $error("full refusal with fill count below capacity");

   a_payload_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != ST_RECEIVED)) |-> (rsp_data.payload_out == '0))
      else $error("nonzero payload on a non-receive result");

   a_recv_after_scan: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == ST_RECEIVED)) |-> $past(busy))
      else $error("received result without a scan");

   a_stored_nonempty: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status == ST_STORED)) |-> (rsp_data.fill_count != '0))
      else $error("stored result with empty fill count");

endmodule

bind typed_fifo_mailbox tfm_checker u_tfm_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

`default_nettype wire
